@@ rtl/core/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_PAY  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		FK_NONE      = 2'd0,
		FK_TEXT      = 2'd1,
		FK_BIN       = 2'd2,
		FK_TEXT_PEND = 2'd3
	} frag_t;

	localparam logic [1:0] KIND_TEXT    = 2'd0;
	localparam logic [1:0] KIND_PING    = 2'd1;
	localparam logic [1:0] KIND_CLOSE   = 2'd2;
	localparam logic [1:0] KIND_ABANDON = 2'd3;

	localparam logic [3:0] OPC_CONT  = 4'h0;
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_BIN   = 4'h2;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [3:0] OPC_PING  = 4'h9;

	localparam logic     OP_BYTE    = 1'b0;
	localparam logic     OP_RESTART = 1'b1;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       msg_start;
		logic       msg_end;
	} out_item_t;

endpackage

@@ rtl/core/wsd_front.sv @@
// front end: header parser and payload classifier, one byte per cycle while in_fire is high
module wsd_front import wsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	phase_t      phase_q;
	logic        fin_q;
	logic [3:0]  opc_q;
	logic        mask_q;
	logic [3:0]  hcnt_q;
	logic [31:0] key_q;
	logic [63:0] rem_q;
	logic [1:0]  pidx_q;
	frag_t       frag_q;
	logic        halt_q;

	phase_t      phase_d;
	logic        fin_d;
	logic [3:0]  opc_d;
	logic        mask_d;
	logic [3:0]  hcnt_d;
	logic [31:0] key_d;
	logic [63:0] rem_d;
	logic [1:0]  pidx_d;
	frag_t       frag_d;
	logic        halt_d;

	logic        emit;
	out_item_t   r;

	logic [7:0]  b;
	logic [6:0]  len7;
	logic [3:0]  hcnt_m1;
	logic        go_begin;
	logic [63:0] len_new;
	logic [7:0]  kbyte;
	logic [7:0]  ub;
	logic        last;
	logic        text_open;
	logic        is_text;
	logic        abandon;
	frag_t       fk_b;

	assign b = item.data_byte;
	assign len7 = b[6:0];
	assign hcnt_m1 = hcnt_q - 4'd1;
	assign text_open = (frag_q == FK_TEXT) || (frag_q == FK_TEXT_PEND);

	// mask byte selected by position, first key byte in the top bits
	always_comb begin
		unique case (pidx_q)
			2'd0: kbyte = key_q[31:24];
			2'd1: kbyte = key_q[23:16];
			2'd2: kbyte = key_q[15:8];
			default: kbyte = key_q[7:0];
		endcase
	end
	assign ub = mask_q ? (b ^ kbyte) : b;
	assign last = (rem_q == 64'd1);
	assign is_text = (opc_q == OPC_TEXT) || ((opc_q == OPC_CONT) && text_open);

	// parser next state and result
	always_comb begin
		phase_d = phase_q;
		fin_d   = fin_q;
		opc_d   = opc_q;
		mask_d  = mask_q;
		hcnt_d  = hcnt_q;
		key_d   = key_q;
		rem_d   = rem_q;
		pidx_d  = pidx_q;
		frag_d  = frag_q;
		halt_d  = halt_q;
		emit    = 1'b0;
		r       = '0;
		go_begin = 1'b0;
		len_new  = rem_q;
		abandon  = 1'b0;
		fk_b     = frag_q;
		if (item.op == OP_RESTART) begin
			phase_d = PH_HDR0;
			fin_d = 1'b0;
			opc_d = '0;
			mask_d = 1'b0;
			hcnt_d = '0;
			key_d = '0;
			rem_d = '0;
			pidx_d = '0;
			frag_d = FK_NONE;
			halt_d = 1'b0;
		end else if (!halt_q) begin
			unique case (phase_q)
				PH_HDR1: begin
					mask_d = b[7];
					if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
						rem_d = '0;
						hcnt_d = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
						phase_d = PH_EXT;
					end else begin
						rem_d = {57'd0, len7};
						len_new = {57'd0, len7};
						if (b[7]) begin
							hcnt_d = 4'd4;
							phase_d = PH_MASK;
						end else begin
							go_begin = 1'b1;
						end
					end
				end
				PH_EXT: begin
					len_new = {rem_q[55:0], b};
					rem_d = len_new;
					hcnt_d = hcnt_m1;
					if (hcnt_m1 == 4'd0) begin
						if (mask_q) begin
							hcnt_d = 4'd4;
							phase_d = PH_MASK;
						end else begin
							go_begin = 1'b1;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], b};
					hcnt_d = hcnt_m1;
					if (hcnt_m1 == 4'd0) go_begin = 1'b1;
				end
				PH_PAY: begin
					pidx_d = pidx_q + 2'd1;
					rem_d = rem_q - 64'd1;
					if (last) phase_d = PH_HDR0;
					if (opc_q == OPC_PING) begin
						emit = 1'b1;
						r.kind = KIND_PING;
						r.payload_byte = ub;
						r.has_byte = 1'b1;
						r.msg_start = (hcnt_q != 4'd0);
						r.msg_end = last;
						hcnt_d = '0;
					end else if (opc_q == OPC_CLOSE) begin
						if (last) begin
							halt_d = 1'b1;
							emit = 1'b1;
							r.kind = KIND_CLOSE;
						end
					end else if (is_text) begin
						emit = 1'b1;
						r.kind = KIND_TEXT;
						r.payload_byte = ub;
						r.has_byte = 1'b1;
						r.msg_start = (frag_q == FK_TEXT_PEND);
						r.msg_end = last && fin_q;
						frag_d = (last && fin_q) ? FK_NONE : FK_TEXT;
					end
				end
				default: begin
					fin_d = b[7];
					opc_d = b[3:0];
					phase_d = PH_HDR1;
				end
			endcase

			// end of header: frame begins
			if (go_begin) begin
				phase_d = PH_PAY;
				pidx_d = '0;
				hcnt_d = (opc_q == OPC_PING) ? 4'd1 : 4'd0;
				if (opc_q == OPC_TEXT) begin
					abandon = text_open;
					fk_b = FK_TEXT_PEND;
				end else if (opc_q == OPC_BIN) begin
					abandon = text_open;
					fk_b = fin_q ? FK_NONE : FK_BIN;
				end else if (opc_q == OPC_CONT && frag_q == FK_BIN && fin_q) begin
					fk_b = FK_NONE;
				end
				frag_d = fk_b;
				if (len_new != 64'd0) begin
					if (abandon) begin
						emit = 1'b1;
						r.kind = KIND_ABANDON;
					end
				end else begin
					phase_d = PH_HDR0;
					hcnt_d = '0;
					if (abandon) begin
						if (fin_q) frag_d = FK_NONE;
						emit = 1'b1;
						r.kind = KIND_ABANDON;
					end else if (opc_q == OPC_CLOSE) begin
						halt_d = 1'b1;
						emit = 1'b1;
						r.kind = KIND_CLOSE;
					end else if (opc_q == OPC_PING) begin
						emit = 1'b1;
						r.kind = KIND_PING;
						r.msg_start = 1'b1;
						r.msg_end = 1'b1;
					end else if (is_text && fin_q) begin
						emit = 1'b1;
						r.kind = KIND_TEXT;
						r.msg_start = (fk_b == FK_TEXT_PEND);
						r.msg_end = 1'b1;
						frag_d = FK_NONE;
					end
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fin_q <= 1'b0;
			opc_q <= '0;
			mask_q <= 1'b0;
			hcnt_q <= '0;
			key_q <= '0;
			rem_q <= '0;
			pidx_q <= '0;
			frag_q <= FK_NONE;
			halt_q <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			fin_q <= fin_d;
			opc_q <= opc_d;
			mask_q <= mask_d;
			hcnt_q <= hcnt_d;
			key_q <= key_d;
			rem_q <= rem_d;
			pidx_q <= pidx_d;
			frag_q <= frag_d;
			halt_q <= halt_d;
		end
	end

	assign res_valid = in_fire && emit;
	assign res = r;

endmodule

@@ rtl/core/wsd_queue.sv @@
// result queue between the parser and the output port
module wsd_queue import wsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  out_item_t wr_item,
	output logic      space,
	output logic      rd_valid,
	output out_item_t rd_item,
	input  logic      rd_en
);

	out_item_t       mem_q [QDEPTH];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [QAW:0]    cnt_q;

	// queue keeps one slot free; the front stalls while three or more results are held
	assign space    = (cnt_q < (QAW+1)'(QDEPTH - 1));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// top level of the websocket frame deframer
// Accepts one link byte (or a restart) per cycle and gives at most one result
// per byte, registered through a four-entry result queue. Throughput is
// one item per cycle; the input stalls only while the result queue holds three
// or more undelivered results, so it is set by how fast the output is drained.
module websocket_frame_deframer import wsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      in_fire;
	logic      res_valid;
	out_item_t res;
	logic      space;

	assign in_stall = !space;
	assign in_fire  = in_valid && space;

	// header parse and classification
	wsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.item     (in_data),
		.res_valid(res_valid),
		.res      (res)
	);

	// result buffering toward the consumer
	wsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_item (res),
		.space   (space),
		.rd_valid(out_valid),
		.rd_item (out_data),
		.rd_en   (out_valid && !out_stall)
	);

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the websocket frame deframer
module testbench;
	import wsd_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	websocket_frame_deframer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state
	phase_t      p_phase;
	logic        p_fin;
	logic [3:0]  p_opc;
	logic        p_masked;
	logic [3:0]  p_hcount;
	logic [31:0] p_key;
	logic [63:0] p_remain;
	logic [1:0]  p_idx;
	frag_t       p_frag;
	logic        p_halted;

	out_item_t expected_q[$];
	int        mismatches = 0;
	int        items_sent;
	int        results_seen = 0;
	int        cycles = 0;
	int        hold_cycles = 0;
	int        hold_req = 0;
	int        hold_ack = 0;
	bit        idle_enable;
	bit        ordered_frames;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic out_item_t mk(logic [1:0] k, logic [7:0] b, logic h, logic s,
		logic e);
		out_item_t r;
		r.kind = k; r.payload_byte = b; r.has_byte = h; r.msg_start = s; r.msg_end = e;
		return r;
	endfunction

	function automatic bit text_is_open();
		return p_frag == FK_TEXT || p_frag == FK_TEXT_PEND;
	endfunction

	function automatic bit frame_is_text();
		return p_opc == OPC_TEXT || (p_opc == OPC_CONT && text_is_open());
	endfunction

	task automatic deframer_reset_state();
		p_phase = PH_HDR0; p_fin = 1'b0; p_opc = '0; p_masked = 1'b0; p_hcount = '0;
		p_key = '0; p_remain = '0; p_idx = '0; p_frag = FK_NONE; p_halted = 1'b0;
	endtask

	// end of header: set up the payload, maybe produce an event
	task automatic frame_header_done();
		bit abandon;
		bit txt;
		abandon = 1'b0;
		p_phase = PH_PAY;
		p_idx = '0;
		p_hcount = (p_opc == OPC_PING) ? 4'd1 : 4'd0;
		if (p_opc == OPC_TEXT) begin
			abandon = text_is_open();
			p_frag = FK_TEXT_PEND;
		end else if (p_opc == OPC_BIN) begin
			abandon = text_is_open();
			p_frag = p_fin ? FK_NONE : FK_BIN;
		end else if (p_opc == OPC_CONT && p_frag == FK_BIN && p_fin) begin
			p_frag = FK_NONE;
		end
		txt = frame_is_text();
		if (p_remain != 64'd0) begin
			if (abandon)
				expected_q.push_back(mk(KIND_ABANDON, 8'd0, 1'b0, 1'b0, 1'b0));
			return;
		end
		p_phase = PH_HDR0;
		p_hcount = '0;
		if (abandon) begin
			if (p_fin) p_frag = FK_NONE;
			expected_q.push_back(mk(KIND_ABANDON, 8'd0, 1'b0, 1'b0, 1'b0));
		end else if (p_opc == OPC_CLOSE) begin
			p_halted = 1'b1;
			expected_q.push_back(mk(KIND_CLOSE, 8'd0, 1'b0, 1'b0, 1'b0));
		end else if (p_opc == OPC_PING) begin
			expected_q.push_back(mk(KIND_PING, 8'd0, 1'b0, 1'b1, 1'b1));
		end else if (txt && p_fin) begin
			expected_q.push_back(mk(KIND_TEXT, 8'd0, 1'b0, p_frag == FK_TEXT_PEND, 1'b1));
			p_frag = FK_NONE;
		end
	endtask

	task automatic payload_byte_in(logic [7:0] b);
		bit last;
		bit txt;
		bit en;
		last = (p_remain == 64'd1);
		txt = frame_is_text();
		if (p_masked) b ^= p_key[8*(3-p_idx) +: 8];
		p_idx = p_idx + 2'd1;
		p_remain = p_remain - 64'd1;
		if (last) p_phase = PH_HDR0;
		if (p_opc == OPC_PING) begin
			expected_q.push_back(mk(KIND_PING, b, 1'b1, p_hcount != 4'd0, last));
			p_hcount = '0;
		end else if (p_opc == OPC_CLOSE) begin
			if (last) begin
				p_halted = 1'b1;
				expected_q.push_back(mk(KIND_CLOSE, 8'd0, 1'b0, 1'b0, 1'b0));
			end
		end else if (txt) begin
			en = last && p_fin;
			expected_q.push_back(mk(KIND_TEXT, b, 1'b1, p_frag == FK_TEXT_PEND, en));
			p_frag = en ? FK_NONE : FK_TEXT;
		end
	endtask

	// advance the predictor by one accepted item
	task automatic deframer_predict(in_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		if (it.op == OP_RESTART) begin
			deframer_reset_state();
			return;
		end
		if (p_halted) return;
		case (p_phase)
			PH_HDR1: begin
				p_masked = b[7];
				if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
					p_remain = '0;
					p_hcount = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
					p_phase = PH_EXT;
				end else begin
					p_remain = {57'd0, b[6:0]};
					if (p_masked) begin
						p_hcount = 4'd4; p_phase = PH_MASK;
					end else frame_header_done();
				end
			end
			PH_EXT: begin
				p_remain = {p_remain[55:0], b};
				p_hcount = p_hcount - 4'd1;
				if (p_hcount == 4'd0) begin
					if (p_masked) begin
						p_hcount = 4'd4; p_phase = PH_MASK;
					end else frame_header_done();
				end
			end
			PH_MASK: begin
				p_key = {p_key[23:0], b};
				p_hcount = p_hcount - 4'd1;
				if (p_hcount == 4'd0) frame_header_done();
			end
			PH_PAY: payload_byte_in(b);
			default: begin
				p_fin = b[7];
				p_opc = b[3:0];
				p_phase = PH_HDR1;
			end
		endcase
	endtask

	// send one item, with a random gap
	task automatic send_item(logic op, logic [7:0] b);
		in_item_t it;
		int gap;
		gap = idle_enable ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.op = op; it.data_byte = b;
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		deframer_predict(it);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// one full frame; enc selects the length encoding
	task automatic send_frame(logic fin, logic [3:0] opc, logic masked, int len, int enc,
		logic [7:0] rsv);
		logic [31:0] key;
		key = $urandom;
		send_byte({fin, rsv[6:4], opc});
		if (enc == 0) send_byte({masked, 7'(len)});
		else if (enc == 1) begin
			send_byte({masked, LEN_EXT16});
			send_byte(len[15:8]); send_byte(len[7:0]);
		end else begin
			send_byte({masked, LEN_EXT64});
			for (int i = 7; i >= 0; i--) send_byte(i >= 4 ? 8'd0 : len[8*i +: 8]);
		end
		if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
		for (int i = 0; i < len; i++) send_byte(8'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				out_item_t e;
				e = expected_q.pop_front();
				if (e.kind !== out_data.kind || e.payload_byte !== out_data.payload_byte ||
					e.has_byte !== out_data.has_byte || e.msg_start !== out_data.msg_start ||
					e.msg_end !== out_data.msg_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, out_data);
				end
			end
		end
	end

	// receiver stall: random, or a long hold when requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= 60;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (idle_enable)
			out_stall <= ($urandom_range(0, 9) < 3);
		else
			out_stall <= 1'b0;
	end

	task automatic test_directed();
		send_frame(1, OPC_TEXT, 0, 0, 0, 0);          // empty final text
		send_frame(1, OPC_TEXT, 1, 3, 0, 8'h70);      // masked, reserved bits set
		send_frame(0, OPC_TEXT, 0, 0, 0, 0);          // empty non-final
		send_frame(0, OPC_CONT, 1, 2, 0, 0);
		send_frame(1, OPC_PING, 0, 0, 0, 0);          // empty ping inside message
		send_frame(1, OPC_PING, 1, 2, 0, 0);
		send_frame(1, OPC_CONT, 0, 1, 0, 0);
		send_frame(1, OPC_CONT, 0, 2, 0, 0);          // orphan continuation
		send_frame(0, OPC_TEXT, 0, 1, 0, 0);
		send_frame(1, OPC_TEXT, 0, 0, 0, 0);          // abandon, empty final lost
		send_frame(0, OPC_BIN, 0, 1, 0, 0);
		send_frame(1, OPC_TEXT, 0, 126, 1, 0);        // 16-bit length over open binary
		send_frame(1, 4'hA, 0, 1, 0, 0);              // pong
		send_frame(1, 4'h3, 0, 1, 0, 0);              // reserved opcode
		send_frame(1, OPC_TEXT, 1, 2, 2, 0);          // 64-bit length
		send_frame(1, OPC_CLOSE, 0, 2, 0, 0);
		send_byte(8'hff); send_byte(8'h00);           // ignored after close
		send_item(OP_RESTART, 8'h55);
		send_byte(8'h81); send_byte(8'hff);           // 64-bit length, max byte value
		for (int i = 0; i < 8; i++) send_byte(i < 7 ? 8'h00 : 8'h02);
		for (int i = 0; i < 6; i++) send_byte(8'($urandom));
		send_item(OP_RESTART, 8'h00);
		wait_drained();
	endtask

	task automatic test_long_hold();
		hold_req++;
		idle_enable = 0;
		send_frame(1, OPC_TEXT, 0, 20, 0, 0);
		idle_enable = 1;
		wait_drained();
	endtask

	task automatic test_random_frames();
		int op_pick;
		logic [3:0] opc;
		while (items_sent < 1440) begin
			op_pick = $urandom_range(0, 19);
			opc = op_pick < 8 ? OPC_TEXT : op_pick < 13 ? OPC_CONT : op_pick < 15 ? OPC_PING :
				op_pick < 16 ? OPC_BIN : op_pick < 17 ? OPC_CLOSE : 4'($urandom);
			if ($urandom_range(0, 29) == 0) send_item(OP_RESTART, 8'($urandom));
			else if ($urandom_range(0, 19) == 0) send_byte(8'($urandom));     // noise
			else send_frame(1'($urandom), opc, 1'($urandom), $urandom_range(0, 12),
				$urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0, 8'($urandom));
			if (p_halted && $urandom_range(0, 3) != 0) send_item(OP_RESTART, 8'($urandom));
			if ($urandom_range(0, 199) == 0) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		items_sent = 0;
		idle_enable = 1;
		deframer_reset_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_hold();
		test_random_frames();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d items (frames of all opcodes, masks, length forms, restarts)",
			items_sent);
		$display("checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
